// ===== src/hbd_pkg.sv =====
// ----------------------------------------------------------------------------
// hbd_pkg: shared definitions of the HTTP/1 body deframer
// Holds the codes, the item types and the character helpers used by the
// deframer's modules.
// ----------------------------------------------------------------------------
package hbd_pkg;

	localparam int SIZE_BITS     = 32;
	localparam int HEADER_BUFFER = 20;

	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_W  = 1;

	localparam logic [CFG_IDX_W-1:0] REG_BODY_MODE      = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CONTENT_LENGTH = 1'd1;

	localparam logic [1:0] MODE_UNTIL_CLOSE = 2'd0;
	localparam logic [1:0] MODE_FIXED       = 2'd1;
	localparam logic [1:0] MODE_CHUNKED     = 2'd2;

	localparam logic [1:0] OP_BYTE  = 2'd0;
	localparam logic [1:0] OP_CLOSE = 2'd1;
	localparam logic [1:0] OP_FAIL  = 2'd2;

	localparam logic [1:0] ST_CONTINUE = 2'd0;
	localparam logic [1:0] ST_ENDED    = 2'd1;
	localparam logic [1:0] ST_ERROR    = 2'd2;
	localparam logic [1:0] ST_IGNORED  = 2'd3;

	localparam logic [2:0] ERR_NONE       = 3'd0;
	localparam logic [2:0] ERR_EARLY_END  = 3'd1;
	localparam logic [2:0] ERR_NON_HEX    = 3'd2;
	localparam logic [2:0] ERR_TOO_LONG   = 3'd3;
	localparam logic [2:0] ERR_NO_LF      = 3'd4;
	localparam logic [2:0] ERR_OVERFLOW   = 3'd5;
	localparam logic [2:0] ERR_TAIL_NO_LF = 3'd6;
	localparam logic [2:0] ERR_LINK       = 3'd7;

	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_LF   = 8'h0A;
	localparam logic [7:0] CH_CR   = 8'h0D;
	localparam logic [7:0] CH_SP   = 8'h20;
	localparam logic [7:0] CH_TAB  = 8'h09;

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] data_byte;
	} item_t;

	typedef struct packed {
		logic       data_valid;
		logic [7:0] out_byte;
		logic [1:0] status;
		logic [2:0] error_code;
	} result_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_t;

	function automatic logic is_lws(input logic [7:0] c);
		return (c == CH_SP) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
	endfunction

	function automatic hex_t hex_decode(input logic [7:0] c);
		hex_t h;
		h.ok  = 1'b1;
		h.val = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			h.val = 4'(c - 8'h30);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			h.val = 4'(c - 8'h57);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			h.val = 4'(c - 8'h37);
		end else begin
			h.ok = 1'b0;
		end
		return h;
	endfunction

endpackage

// ===== src/hbd_if.sv =====
// ----------------------------------------------------------------------------
// hbd_if: item channels of the HTTP/1 body deframer
// Valid/ready channels for the received items and for the result items.
// ----------------------------------------------------------------------------
interface hbd_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] opcode;
	logic [7:0] data_byte;

	modport source (output valid, output opcode, output data_byte, input ready);
	modport sink   (input valid, input opcode, input data_byte, output ready);
	modport mon    (input valid, input opcode, input data_byte, input ready);
endinterface

interface hbd_out_if;
	logic       valid;
	logic       ready;
	logic       data_valid;
	logic [7:0] out_byte;
	logic [1:0] status;
	logic [2:0] error_code;

	modport source (output valid, output data_valid, output out_byte, output status,
		output error_code, input ready);
	modport sink   (input valid, input data_valid, input out_byte, input status,
		input error_code, output ready);
	modport mon    (input valid, input data_valid, input out_byte, input status,
		input error_code, input ready);
endinterface

// ===== src/http_body_deframer_top.sv =====
// ----------------------------------------------------------------------------
// http_body_deframer_top: HTTP/1 message body deframer
// Passes the body bytes of a received stream through and reports the end of
// the body or a framing error, for until-close, fixed-length and chunked
// framing.
//
//   Channel   Direction  Handshake     Payload
//   in_ch     in         valid/ready   opcode, data_byte
//   out_ch    out        valid/ready   data_valid, out_byte, status, error_code
//   cfg       in         cfg_we        cfg_index, cfg_wdata
//
// One item is taken per cycle while the input register can take it; its
// result is presented once it has passed from the input register through
// the combinational framing logic into the result register. Reset clears
// all state and the valid flags of both registers. A stalled output holds
// its result, and the input keeps taking items until both registers are full.
// ----------------------------------------------------------------------------
module http_body_deframer_top #(
	parameter int SIZE_BITS     = hbd_pkg::SIZE_BITS,
	parameter int HEADER_BUFFER = hbd_pkg::HEADER_BUFFER
) (
	input  logic                            clk,
	input  logic                            arst_n,
	hbd_in_if.sink                          in_ch,
	hbd_out_if.source                       out_ch,
	input  logic                            cfg_we,
	input  logic [hbd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [hbd_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

	logic             valid_s1;
	hbd_pkg::item_t   item_s1;
	logic             advance;
	logic             out_free;
	hbd_pkg::result_t res;

	assign advance = valid_s1 && out_free;

	hbd_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	hbd_core #(
		.SIZE_BITS     (SIZE_BITS),
		.HEADER_BUFFER (HEADER_BUFFER)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.step      (advance),
		.item      (item_s1),
		.res       (res)
	);

	hbd_out_reg u_out_reg (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (valid_s1),
		.res    (res),
		.free   (out_free),
		.out_ch (out_ch)
	);

endmodule

// ===== src/hbd_in_reg.sv =====
// ----------------------------------------------------------------------------
// hbd_in_reg: input register stage
// Captures one received item per cycle while ready, and holds it until the core takes it.
// ----------------------------------------------------------------------------
module hbd_in_reg (
	input  logic            clk,
	input  logic            arst_n,
	hbd_in_if.sink          in_ch,
	input  logic            advance,
	output logic            valid_s1,
	output hbd_pkg::item_t  item_s1
);

	logic load;

	assign in_ch.ready = !valid_s1 || advance;
	assign load        = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1.opcode    <= in_ch.opcode;
			item_s1.data_byte <= in_ch.data_byte;
		end
	end

endmodule

// ===== src/hbd_core.sv =====
// ----------------------------------------------------------------------------
// hbd_core: framing state machine
// Holds the configuration and the framing state, and works out the result
// of one item combinationally.
// ----------------------------------------------------------------------------
module hbd_core #(
	parameter int SIZE_BITS     = hbd_pkg::SIZE_BITS,
	parameter int HEADER_BUFFER = hbd_pkg::HEADER_BUFFER
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [hbd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [hbd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                            step,
	input  hbd_pkg::item_t                  item,
	output hbd_pkg::result_t                res
);

	localparam int REM_W = (SIZE_BITS > 32) ? SIZE_BITS : 32;
	localparam int CNT_W = $clog2(HEADER_BUFFER + 1);

	typedef enum logic [3:0] {
		PH_START, PH_EOF, PH_FIXED, PH_LWS, PH_HEX,
		PH_TRAIL, PH_DATA, PH_TAIL0, PH_TAIL1, PH_DONE
	} phase_t;

	phase_t             phase_q, phase_d, eff_phase;
	logic [REM_W-1:0]   rem_q, rem_d, eff_rem;
	logic [CNT_W-1:0]   cnt_q, cnt_d, cnt_inc;
	logic               first_zero_q, first_zero_d;
	logic               ovf_q, ovf_d;
	logic [1:0]         body_mode_q;
	logic [31:0]        content_length_q;
	logic               early_end;
	hbd_pkg::hex_t      hv;
	logic [7:0]         c;
	phase_t             se_phase;
	logic [1:0]         se_status;
	logic [2:0]         se_err;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			body_mode_q      <= hbd_pkg::MODE_UNTIL_CLOSE;
			content_length_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				hbd_pkg::REG_BODY_MODE:      body_mode_q      <= cfg_wdata[1:0];
				hbd_pkg::REG_CONTENT_LENGTH: content_length_q <= cfg_wdata[31:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		c   = item.data_byte;
		hv  = hbd_pkg::hex_decode(c);
		cnt_inc = cnt_q + CNT_W'(1);

		eff_phase = phase_q;
		eff_rem   = rem_q;
		early_end = 1'b0;
		if (phase_q == PH_START) begin
			unique case (body_mode_q)
				hbd_pkg::MODE_FIXED: begin
					eff_phase = PH_FIXED;
					eff_rem   = REM_W'(content_length_q);
					early_end = (content_length_q == 32'd0);
				end
				hbd_pkg::MODE_CHUNKED: eff_phase = PH_LWS;
				default:               eff_phase = PH_EOF;
			endcase
		end

		// Byte after the size digits or after trailing whitespace.
		se_phase  = eff_phase;
		se_status = hbd_pkg::ST_CONTINUE;
		se_err    = hbd_pkg::ERR_NONE;
		if (c == hbd_pkg::CH_LF) begin
			if (ovf_q) begin
				se_status = hbd_pkg::ST_ERROR;
				se_err    = hbd_pkg::ERR_OVERFLOW;
			end else begin
				se_phase = (rem_q != '0) ? PH_DATA : PH_TAIL0;
			end
		end else if (hbd_pkg::is_lws(c)) begin
			se_phase = PH_TRAIL;
		end else begin
			se_status = hbd_pkg::ST_ERROR;
			se_err    = hbd_pkg::ERR_NO_LF;
		end

		res          = '0;
		phase_d      = eff_phase;
		rem_d        = eff_rem;
		cnt_d        = cnt_q;
		first_zero_d = first_zero_q;
		ovf_d        = ovf_q;

		if (early_end) begin
			res.status = hbd_pkg::ST_ENDED;
		end else if (eff_phase == PH_DONE) begin
			res.status = hbd_pkg::ST_IGNORED;
		end else if (item.opcode != hbd_pkg::OP_BYTE) begin
			if (item.opcode == hbd_pkg::OP_CLOSE && eff_phase == PH_EOF) begin
				res.status = hbd_pkg::ST_ENDED;
			end else begin
				res.status     = hbd_pkg::ST_ERROR;
				res.error_code = (item.opcode == hbd_pkg::OP_CLOSE) ?
					hbd_pkg::ERR_EARLY_END : hbd_pkg::ERR_LINK;
			end
		end else begin
			unique case (eff_phase)
				PH_EOF: begin
					res.data_valid = 1'b1;
					res.out_byte   = c;
				end
				PH_FIXED, PH_DATA: begin
					res.data_valid = 1'b1;
					res.out_byte   = c;
					rem_d          = eff_rem - REM_W'(1);
					if (eff_rem == REM_W'(1)) begin
						if (eff_phase == PH_FIXED) begin
							res.status = hbd_pkg::ST_ENDED;
						end else begin
							phase_d = PH_LWS;
						end
					end
				end
				PH_LWS: begin
					if (!hbd_pkg::is_lws(c)) begin
						if (!hv.ok) begin
							res.status     = hbd_pkg::ST_ERROR;
							res.error_code = hbd_pkg::ERR_NON_HEX;
						end else begin
							rem_d        = REM_W'(hv.val);
							ovf_d        = 1'b0;
							cnt_d        = CNT_W'(1);
							first_zero_d = (c == hbd_pkg::CH_ZERO);
							phase_d      = PH_HEX;
						end
					end
				end
				PH_HEX: begin
					if (cnt_q == CNT_W'(1) && first_zero_q && c == hbd_pkg::CH_ZERO) begin
						phase_d = PH_HEX;
					end else if (!hv.ok) begin
						phase_d        = se_phase;
						res.status     = se_status;
						res.error_code = se_err;
					end else begin
						if (!ovf_q) begin
							if ((rem_q >> (SIZE_BITS - 4)) != '0) begin
								ovf_d = 1'b1;
							end else begin
								rem_d = {rem_q[REM_W-5:0], hv.val};
							end
						end
						cnt_d = cnt_inc;
						if (cnt_inc >= CNT_W'(HEADER_BUFFER)) begin
							res.status     = hbd_pkg::ST_ERROR;
							res.error_code = hbd_pkg::ERR_TOO_LONG;
						end
					end
				end
				PH_TRAIL: begin
					phase_d        = se_phase;
					res.status     = se_status;
					res.error_code = se_err;
				end
				PH_TAIL0: begin
					if (c == hbd_pkg::CH_CR) begin
						phase_d = PH_TAIL1;
					end else if (c == hbd_pkg::CH_LF) begin
						res.status = hbd_pkg::ST_ENDED;
					end else begin
						res.status     = hbd_pkg::ST_ERROR;
						res.error_code = hbd_pkg::ERR_TAIL_NO_LF;
					end
				end
				PH_TAIL1: begin
					if (c == hbd_pkg::CH_LF) begin
						res.status = hbd_pkg::ST_ENDED;
					end else begin
						res.status     = hbd_pkg::ST_ERROR;
						res.error_code = hbd_pkg::ERR_TAIL_NO_LF;
					end
				end
				default: ;
			endcase
		end

		if (res.status == hbd_pkg::ST_ENDED || res.status == hbd_pkg::ST_ERROR) begin
			phase_d = PH_DONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_START;
			rem_q        <= '0;
			cnt_q        <= '0;
			first_zero_q <= 1'b0;
			ovf_q        <= 1'b0;
		end else if (step) begin
			phase_q      <= phase_d;
			rem_q        <= rem_d;
			cnt_q        <= cnt_d;
			first_zero_q <= first_zero_d;
			ovf_q        <= ovf_d;
		end
	end

endmodule

// ===== src/hbd_out_reg.sv =====
// ----------------------------------------------------------------------------
// hbd_out_reg: result register
// Holds one result item until the downstream side takes it.
// ----------------------------------------------------------------------------
module hbd_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  hbd_pkg::result_t  res,
	output logic              free,
	hbd_out_if.source         out_ch
);

	logic             valid_q;
	hbd_pkg::result_t res_q;

	assign free = !valid_q || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && free) begin
			res_q <= res;
		end
	end

	assign out_ch.valid      = valid_q;
	assign out_ch.data_valid = res_q.data_valid;
	assign out_ch.out_byte   = res_q.out_byte;
	assign out_ch.status     = res_q.status;
	assign out_ch.error_code = res_q.error_code;

endmodule

// ===== src/hbd_checker.sv =====
// ----------------------------------------------------------------------------
// hbd_checker: port-level checks of the body deframer
// Watches the result channel for stalled items held stable, for consistent
// codes and for the finished condition holding until reset.
// ----------------------------------------------------------------------------
module hbd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic       out_data_valid,
	input logic [7:0] out_byte,
	input logic [1:0] out_status,
	input logic [2:0] out_error_code
);

	logic finished_q;
	logic out_fire;

	assign out_fire = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			finished_q <= 1'b0;
		end else if (out_fire && (out_status == hbd_pkg::ST_ENDED ||
				out_status == hbd_pkg::ST_ERROR)) begin
			finished_q <= 1'b1;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_status)
		&& $stable(out_byte) && $stable(out_error_code))
		else $error("stalled result item changed");

	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((out_error_code != hbd_pkg::ERR_NONE) ==
		(out_status == hbd_pkg::ST_ERROR)))
		else $error("error code does not match status");

	a_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data_valid |-> (out_status == hbd_pkg::ST_CONTINUE ||
		out_status == hbd_pkg::ST_ENDED))
		else $error("payload byte carried with error or ignored status");

	a_after_finish: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && finished_q |-> out_status == hbd_pkg::ST_IGNORED)
		else $error("result after the end of the body was not ignored");

	a_ignored_only_after: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !finished_q |-> out_status != hbd_pkg::ST_IGNORED)
		else $error("item ignored before the body finished");

endmodule

bind http_body_deframer_top hbd_checker u_hbd_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_ch.valid),
	.out_ready      (out_ch.ready),
	.out_data_valid (out_ch.data_valid),
	.out_byte       (out_ch.out_byte),
	.out_status     (out_ch.status),
	.out_error_code (out_ch.error_code)
);
